// ----- design/k_way_heap_merge_macros.svh -----
// ----------------------------------------------------------------------------
// k_way_heap_merge_macros
// Assertion macros for the heap merge engine; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef K_WAY_HEAP_MERGE_MACROS_SVH
`define K_WAY_HEAP_MERGE_MACROS_SVH

`ifndef SYNTHESIS
`define KWHM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define KWHM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KWHM_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define KWHM_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- design/kwhm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwhm_pkg
// Shared types, codes and widths of the heap merge engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kwhm_pkg;

    localparam int DEF_MAX_WAYS = 16;
    localparam int KEY_W        = 32;
    localparam int SEQ_W        = 4;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 2;
    localparam int S_TDATA_W    = ((SEQ_W + KEY_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_BUILD   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_EXHAUST = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_TAKE,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [SEQ_W-1:0]        seq;
    } entry_t;

    function automatic logic key_less(input entry_t a, input entry_t b);
        return a.key < b.key;
    endfunction

endpackage

`default_nettype wire

// ----- design/k_way_heap_merge.sv -----
// ----------------------------------------------------------------------------
// k_way_heap_merge
// Min-heap engine for merging up to MAX_WAYS sorted sequences.
// ----------------------------------------------------------------------------
// One op is handled at a time; every op returns one result transaction with
// the root entry, the entry count and a status. Entries live in a memory with
// two registered read ports and one write port. A load, a rejected op or an
// exhausted that empties the heap goes from acceptance straight to S_DONE.
// A sift-down passes S_SIFT_RD and S_SIFT_CMP per level (read both children,
// then compare and write back through the single write port), at most
// log2(MAX_WAYS)+1 compare steps. Advance starts the sift at the root at once;
// exhausted first takes the last entry into the root slot through S_TAKE.
// Build runs one such sift, after S_FETCH and S_TAKE, for each of the count/2
// inner nodes, from the last one up to the root. The next op is accepted as
// soon as the result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_way_heap_merge_macros.svh"

module k_way_heap_merge #(
    parameter int MAX_WAYS = kwhm_pkg::DEF_MAX_WAYS,
    localparam int NW      = $clog2(MAX_WAYS + 1),
    localparam int MDW     = ((kwhm_pkg::KEY_W + kwhm_pkg::SEQ_W + NW + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // seq_index[3:0], key[35:4]
    input  wire logic [kwhm_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  wire logic [kwhm_pkg::OP_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // min_key[31:0], min_seq[35:32], entries[36+NW-1:36]
    output logic [MDW-1:0]                      m_tdata,
    // status[1:0]
    output logic [kwhm_pkg::STAT_W-1:0]         m_tuser
);

    localparam int AW = $clog2(MAX_WAYS);
    localparam int CW = AW + 2;

    kwhm_pkg::state_t  state_reg, state_next;
    logic [NW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     bld_reg, bld_next;
    logic              bld_mode_reg, bld_mode_next;
    kwhm_pkg::entry_t  x_reg, x_next;
    kwhm_pkg::entry_t  root_reg;
    kwhm_pkg::status_t status_reg, status_next;

    kwhm_pkg::op_t     in_op;
    kwhm_pkg::entry_t  in_ent;
    logic              s_acc;
    logic [CW-1:0]     lch;
    logic [CW-1:0]     rch;
    logic              l_ok, r_ok, take_l, take_r;
    kwhm_pkg::entry_t  cand;
    logic [NW-1:0]     half_m1;
    logic [NW-1:0]     cnt_m1;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    kwhm_pkg::entry_t  mem_wdata;
    logic [AW-1:0]     ra_addr, rb_addr;
    kwhm_pkg::entry_t  ra_data, rb_data;
    logic              out_push, out_free;

    assign in_op      = kwhm_pkg::op_t'(s_tuser);
    assign in_ent.seq = s_tdata[kwhm_pkg::SEQ_W-1:0];
    assign in_ent.key = s_tdata[kwhm_pkg::SEQ_W +: kwhm_pkg::KEY_W];
    assign s_tready   = (state_reg == kwhm_pkg::S_IDLE);
    assign s_acc      = s_tvalid && s_tready;

    assign lch     = {1'b0, pos_reg, 1'b1};
    assign rch     = lch + CW'(1);
    assign l_ok    = lch < CW'(count_reg);
    assign r_ok    = rch < CW'(count_reg);
    assign take_l  = l_ok && kwhm_pkg::key_less(ra_data, x_reg);
    assign cand    = take_l ? ra_data : x_reg;
    assign take_r  = r_ok && kwhm_pkg::key_less(rb_data, cand);
    assign half_m1 = (count_reg >> 1) - NW'(1);
    assign cnt_m1  = count_reg - NW'(1);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        bld_next      = bld_reg;
        bld_mode_next = bld_mode_reg;
        x_next        = x_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = x_reg;
        ra_addr       = lch[AW-1:0];
        rb_addr       = rch[AW-1:0];
        out_push      = 1'b0;
        unique case (state_reg)
            kwhm_pkg::S_IDLE: begin
                if (s_acc) begin
                    status_next   = kwhm_pkg::ST_OK;
                    bld_mode_next = 1'b0;
                    state_next    = kwhm_pkg::S_DONE;
                    if (in_op == kwhm_pkg::OP_LOAD) begin
                        if (count_reg == NW'(MAX_WAYS)) begin
                            status_next = kwhm_pkg::ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = in_ent;
                            count_next = count_reg + NW'(1);
                        end
                    end else if (count_reg == '0) begin
                        status_next = kwhm_pkg::ST_EMPTY;
                    end else begin
                        unique case (in_op)
                            kwhm_pkg::OP_BUILD: begin
                                if (count_reg >= NW'(2)) begin
                                    bld_mode_next = 1'b1;
                                    bld_next      = half_m1[AW-1:0];
                                    state_next    = kwhm_pkg::S_FETCH;
                                end
                            end
                            kwhm_pkg::OP_ADVANCE: begin
                                x_next.key = in_ent.key;
                                x_next.seq = root_reg.seq;
                                pos_next   = '0;
                                state_next = kwhm_pkg::S_SIFT_RD;
                            end
                            default: begin
                                count_next = cnt_m1;
                                if (cnt_m1 != '0) begin
                                    ra_addr    = cnt_m1[AW-1:0];
                                    pos_next   = '0;
                                    state_next = kwhm_pkg::S_TAKE;
                                end
                            end
                        endcase
                    end
                end
            end
            kwhm_pkg::S_FETCH: begin
                ra_addr    = bld_reg;
                pos_next   = bld_reg;
                state_next = kwhm_pkg::S_TAKE;
            end
            kwhm_pkg::S_TAKE: begin
                x_next     = ra_data;
                state_next = kwhm_pkg::S_SIFT_RD;
            end
            kwhm_pkg::S_SIFT_RD: begin
                state_next = kwhm_pkg::S_SIFT_CMP;
            end
            kwhm_pkg::S_SIFT_CMP: begin
                mem_we = 1'b1;
                if (take_r) begin
                    mem_wdata  = rb_data;
                    pos_next   = rch[AW-1:0];
                    state_next = kwhm_pkg::S_SIFT_RD;
                end else if (take_l) begin
                    mem_wdata  = ra_data;
                    pos_next   = lch[AW-1:0];
                    state_next = kwhm_pkg::S_SIFT_RD;
                end else if (bld_mode_reg && bld_reg != '0) begin
                    bld_next   = bld_reg - AW'(1);
                    state_next = kwhm_pkg::S_FETCH;
                end else begin
                    state_next = kwhm_pkg::S_DONE;
                end
            end
            kwhm_pkg::S_DONE: begin
                if (out_free) begin
                    out_push   = 1'b1;
                    state_next = kwhm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = kwhm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kwhm_pkg::S_IDLE;
            count_reg    <= '0;
            bld_mode_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            bld_mode_reg <= bld_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        bld_reg    <= bld_next;
        x_reg      <= x_next;
        status_reg <= status_next;
        if (mem_we && mem_waddr == '0) begin
            root_reg <= mem_wdata;
        end
    end

    kwhm_mem #(
        .DEPTH (MAX_WAYS)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .ra_addr (ra_addr),
        .rb_addr (rb_addr),
        .ra_data (ra_data),
        .rb_data (rb_data)
    );

    kwhm_out #(
        .NW (NW)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (out_push),
        .root     (root_reg),
        .count    (count_reg),
        .status   (status_reg),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `KWHM_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= NW'(MAX_WAYS), "entry count above capacity")
    `KWHM_ASSERT_IMP(a_load_addr, aclk, aresetn, mem_we && state_reg == kwhm_pkg::S_IDLE, mem_waddr == count_reg[AW-1:0], "load written off the heap tail")
    `KWHM_ASSERT_IMP(a_sift_pos, aclk, aresetn, state_reg == kwhm_pkg::S_SIFT_RD, CW'(pos_reg) < CW'(count_reg), "sift position outside heap")
    `KWHM_ASSERT_NXT(a_empty_done, aclk, aresetn, s_acc && count_reg == '0 && in_op != kwhm_pkg::OP_LOAD, state_reg == kwhm_pkg::S_DONE && status_reg == kwhm_pkg::ST_EMPTY, "op on empty heap not flagged")

endmodule

`default_nettype wire

// ----- design/kwhm_mem.sv -----
// ----------------------------------------------------------------------------
// kwhm_mem
// Heap entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_mem #(
    parameter int DEPTH = kwhm_pkg::DEF_MAX_WAYS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire kwhm_pkg::entry_t wdata,
    input  wire logic [AW-1:0]    ra_addr,
    input  wire logic [AW-1:0]    rb_addr,
    output kwhm_pkg::entry_t      ra_data,
    output kwhm_pkg::entry_t      rb_data
);

    kwhm_pkg::entry_t ram_reg [DEPTH];
    kwhm_pkg::entry_t ra_reg;
    kwhm_pkg::entry_t rb_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        ra_reg <= ram_reg[ra_addr];
        rb_reg <= ram_reg[rb_addr];
    end

    assign ra_data = ra_reg;
    assign rb_data = rb_reg;

endmodule

`default_nettype wire

// ----- design/kwhm_out.sv -----
// ----------------------------------------------------------------------------
// kwhm_out
// Result register: packs root, entry count and status into one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_out #(
    parameter int NW     = 5,
    localparam int MDW   = ((kwhm_pkg::KEY_W + kwhm_pkg::SEQ_W + NW + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire kwhm_pkg::entry_t              root,
    input  wire logic [NW-1:0]                 count,
    input  wire kwhm_pkg::status_t             status,
    output logic                               free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [MDW-1:0]                     m_tdata,
    output logic [kwhm_pkg::STAT_W-1:0]        m_tuser
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [MDW-1:0]              data_reg;
    logic [kwhm_pkg::STAT_W-1:0] user_reg;
    kwhm_pkg::entry_t            shown;

    assign free = !valid_reg || m_tready;

    always_comb begin
        shown = (count != '0) ? root : '0;
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= MDW'({count, shown.seq, shown.key});
            user_reg <= status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire
